// ===== src/tlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfq_pkg
// types and constants shared by the two-level feedback queue scheduler
// ----------------------------------------------------------------------------
package tlfq_pkg;

    localparam int unsigned QUANTUM_RESET = 20;
    localparam int unsigned BOOST_RESET   = 100;

    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_BOOST   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK,
        ST_EXEC,
        ST_OUT
    } state_t;

    // per-slot record held in the job table
    typedef struct packed {
        logic [15:0] work_left;
        logic [15:0] allot_left;
        logic [15:0] allot_full;
        logic [31:0] arrived_at;
        logic [31:0] started_at;
    } job_rec_t;

    localparam int unsigned JOB_REC_W = $bits(job_rec_t);

endpackage

// ===== src/tlfq_ram.sv =====
// ----------------------------------------------------------------------------
// tlfq_ram
// single-port-write, single-port-read synchronous ram, registered read
// ----------------------------------------------------------------------------
module tlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/two_level_feedback_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// two_level_feedback_queue_scheduler
// two-level feedback queue scheduler, one request per time tick
// ----------------------------------------------------------------------------
// Each request on s_axis is one tick, optionally carrying a job arrival.
// One result is produced on m_axis per request: the job that ran this tick,
// its level, completion statistics, and rejection and boost flags.
// Job state lives in two synchronous rams: a link table for both queues and
// a job table holding work, allotment and time stamps per slot.
// After the request is taken, ST_LINK writes an arrival and issues the link
// and job reads for the pick, ST_EXEC pops the queue, runs the tick and
// writes back, then the result register holds the result in ST_OUT.
// Requests are taken one at a time, only in ST_IDLE after the result is taken.
// A second link write in the same tick is held and done while the result waits.
// Configuration writes on cfg_* are to be made only while idle; the block
// itself does not enforce this.
// Reset (aresetn low, synchronous) empties both queues, clears all slots
// and loads the register reset values; the rams need no clearing.
// When m_axis_tready is low the result is held and no new request is taken.
// ----------------------------------------------------------------------------
module two_level_feedback_queue_scheduler #(
    parameter int MAX_JOBS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action, arriving_job, burst_length, allotment (zero-filled to 40 bits)
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // running_valid, running_job, running_level, finished, end_time,
    // turnaround, response_time, arrival_rejected, boosted (to 112 bits)
    output logic [111:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data
);
    import tlfq_pkg::*;

    localparam int SW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    state_t state_reg, state_next;

    logic [7:0]  quantum_reg;
    logic [15:0] boost_period_reg;

    logic [SW-1:0] high_head_reg, high_tail_reg, low_head_reg, low_tail_reg;
    logic          high_empty_reg, low_empty_reg;
    logic [SW-1:0] hh_next, ht_next, lh_next, lt_next;
    logic          he_next, le_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [SW-1:0] cur_job_reg, cur_job_next;
    logic          cur_level_reg, cur_level_next;
    logic [7:0]    qleft_reg, qleft_next;
    logic [31:0]   tick_reg, tick_next;
    logic [15:0]   bcount_reg, bcount_next;
    logic [MAX_JOBS-1:0] active_reg, active_next, started_reg, started_next;

    logic          in_action;
    logic [3:0]    in_slot;
    logic [15:0]   in_burst, in_allot;
    logic          act_reg;
    logic [3:0]    slot_reg;
    logic [15:0]   burst_reg, allot_reg;
    logic          rej_reg, rej_next;

    logic [111:0]  out_reg, out_next;
    logic          picked_reg, picked_next;
    logic          pick_low_reg, pick_low_next;

    // link ram
    logic          ln_we;
    logic [SW-1:0] ln_wa, ln_wd, ln_ra, ln_rd;
    // job ram
    logic          jb_we;
    logic [SW-1:0] jb_wa, jb_ra;
    job_rec_t      jb_wd, jb_rd;

    // forwarding of a write to the entry read in the same cycle
    logic          ln_fwd_reg, ln_fwd_next;
    logic [SW-1:0] ln_fwd_data_reg, ln_fwd_data_next;
    logic          jb_fwd_reg, jb_fwd_next;
    job_rec_t      jb_fwd_data_reg, jb_fwd_data_next;
    logic [SW-1:0] ln_rd_eff;
    job_rec_t      jb_rd_eff;

    // held second link write of a tick
    logic          ln_pend_reg, ln_pend_next;
    logic [SW-1:0] ln_pend_addr_reg, ln_pend_addr_next;
    logic [SW-1:0] ln_pend_data_reg, ln_pend_data_next;

    tlfq_ram #(.WIDTH(SW), .DEPTH(MAX_JOBS)) u_link (
        .aclk(aclk), .wr_en(ln_we), .wr_addr(ln_wa), .wr_data(ln_wd),
        .rd_addr(ln_ra), .rd_data(ln_rd)
    );

    tlfq_ram #(.WIDTH(JOB_REC_W), .DEPTH(MAX_JOBS)) u_job (
        .aclk(aclk), .wr_en(jb_we), .wr_addr(jb_wa), .wr_data(jb_wd),
        .rd_addr(jb_ra), .rd_data(jb_rd)
    );

    assign in_action = s_axis_tdata[0];
    assign in_slot   = s_axis_tdata[4:1];
    assign in_burst  = s_axis_tdata[20:5];
    assign in_allot  = s_axis_tdata[36:21];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    assign ln_rd_eff = ln_fwd_reg ? ln_fwd_data_reg : ln_rd;
    assign jb_rd_eff = jb_fwd_reg ? jb_fwd_data_reg : jb_rd;

    // slot index of the incoming request, truncated to table width
    logic [SW-1:0] slot_idx;
    logic          slot_ok;
    always_comb begin
        slot_idx = SW'(slot_reg);
        slot_ok  = ({28'd0, slot_reg} < 32'(MAX_JOBS)) && !active_reg[slot_idx];
    end

    job_rec_t rec_w;
    logic [15:0] wl, al;
    logic [7:0]  qn;

    always_comb begin
        state_next     = state_reg;
        hh_next        = high_head_reg;
        ht_next        = high_tail_reg;
        lh_next        = low_head_reg;
        lt_next        = low_tail_reg;
        he_next        = high_empty_reg;
        le_next        = low_empty_reg;
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        cur_level_next = cur_level_reg;
        qleft_next     = qleft_reg;
        tick_next      = tick_reg;
        bcount_next    = bcount_reg;
        active_next    = active_reg;
        started_next   = started_reg;
        rej_next       = rej_reg;
        out_next       = out_reg;
        picked_next    = picked_reg;
        pick_low_next  = pick_low_reg;
        ln_fwd_next       = ln_fwd_reg;
        ln_fwd_data_next  = ln_fwd_data_reg;
        jb_fwd_next       = jb_fwd_reg;
        jb_fwd_data_next  = jb_fwd_data_reg;
        ln_pend_next      = ln_pend_reg;
        ln_pend_addr_next = ln_pend_addr_reg;
        ln_pend_data_next = ln_pend_data_reg;
        ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = '0;
        jb_we = 1'b0; jb_wa = '0; jb_wd = '0; jb_ra = cur_job_reg;
        rec_w = jb_rd_eff;
        wl = '0; al = '0; qn = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                // arrival write, then pick and issue head link read
                rej_next = 1'b0;
                if (act_reg) begin
                    if (!slot_ok) begin
                        rej_next = 1'b1;
                    end else begin
                        jb_we = 1'b1;
                        jb_wa = slot_idx;
                        jb_wd.work_left  = (burst_reg == 16'd0) ? 16'd1 : burst_reg;
                        jb_wd.allot_full = (allot_reg == 16'd0) ? 16'd1 : allot_reg;
                        jb_wd.allot_left = (allot_reg == 16'd0) ? 16'd1 : allot_reg;
                        jb_wd.arrived_at = tick_reg;
                        jb_wd.started_at = '0;
                        started_next[slot_idx] = 1'b0;
                        active_next[slot_idx]  = 1'b1;
                        if (high_empty_reg) begin
                            hh_next = slot_idx;
                            ht_next = slot_idx;
                            he_next = 1'b0;
                        end else begin
                            ln_we = 1'b1;
                            ln_wa = high_tail_reg;
                            ln_wd = slot_idx;
                            ht_next = slot_idx;
                        end
                    end
                end
                picked_next = 1'b0;
                if (!cur_valid_reg) begin
                    if (!he_next) begin
                        cur_job_next   = hh_next;
                        cur_level_next = 1'b0;
                        cur_valid_next = 1'b1;
                        picked_next    = 1'b1;
                        pick_low_next  = 1'b0;
                        ln_ra = hh_next;
                    end else if (!low_empty_reg) begin
                        cur_job_next   = low_head_reg;
                        cur_level_next = 1'b1;
                        cur_valid_next = 1'b1;
                        picked_next    = 1'b1;
                        pick_low_next  = 1'b1;
                        ln_ra = low_head_reg;
                    end
                    if (cur_valid_next) begin
                        qleft_next = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
                    end
                end
                jb_ra = cur_job_next;
                ln_fwd_next      = ln_we && (ln_wa == ln_ra);
                ln_fwd_data_next = ln_wd;
                jb_fwd_next      = jb_we && (jb_wa == jb_ra);
                jb_fwd_data_next = jb_wd;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // pop using link read data, then run one tick
                if (picked_reg) begin
                    if (pick_low_reg) begin
                        if (low_head_reg == low_tail_reg) le_next = 1'b1;
                        else lh_next = ln_rd_eff;
                    end else begin
                        if (high_head_reg == high_tail_reg) he_next = 1'b1;
                        else hh_next = ln_rd_eff;
                    end
                end
                out_next = '0;
                out_next[103] = rej_reg;
                if (cur_valid_reg) begin
                    out_next[0]   = 1'b1;
                    out_next[4:1] = 4'(cur_job_reg);
                    out_next[5]   = cur_level_reg;
                    if (!started_reg[cur_job_reg]) begin
                        started_next[cur_job_reg] = 1'b1;
                        rec_w.started_at = tick_reg;
                    end
                    wl = jb_rd_eff.work_left - 16'd1;
                    al = jb_rd_eff.allot_left - 16'd1;
                    qn = qleft_reg - 8'd1;
                    rec_w.work_left  = wl;
                    rec_w.allot_left = al;
                    qleft_next = qn;
                    tick_next  = tick_reg + 32'd1;
                    bcount_next = bcount_reg - 16'd1;
                    if (bcount_next == 16'd0) begin
                        out_next[104] = 1'b1;
                        bcount_next = boost_period_reg;
                        if (cur_level_reg) cur_level_next = 1'b0;
                        if (!le_next) begin
                            if (he_next) begin
                                hh_next = lh_next;
                                ht_next = lt_next;
                                he_next = 1'b0;
                            end else begin
                                ln_we = 1'b1;
                                ln_wa = ht_next;
                                ln_wd = lh_next;
                                ht_next = lt_next;
                            end
                            le_next = 1'b1;
                            lh_next = '0;
                            lt_next = '0;
                        end
                    end
                    jb_we = 1'b1;
                    jb_wa = cur_job_reg;
                    if (wl == 16'd0) begin
                        out_next[6]      = 1'b1;
                        out_next[38:7]   = tick_next;
                        out_next[70:39]  = tick_next - jb_rd_eff.arrived_at;
                        out_next[102:71] = rec_w.started_at - jb_rd_eff.arrived_at;
                        active_next[cur_job_reg] = 1'b0;
                        cur_valid_next = 1'b0;
                    end else if (al == 16'd0 || qn == 8'd0) begin
                        // demotion or rotation to a queue tail
                        if (al == 16'd0) rec_w.allot_left = jb_rd_eff.allot_full;
                        cur_valid_next = 1'b0;
                        if (al == 16'd0 || cur_level_next) begin
                            if (le_next) begin
                                lh_next = cur_job_reg;
                                lt_next = cur_job_reg;
                                le_next = 1'b0;
                            end else begin
                                ln_we = 1'b1;
                                ln_wa = lt_next;
                                ln_wd = cur_job_reg;
                                lt_next = cur_job_reg;
                            end
                        end else begin
                            if (he_next) begin
                                hh_next = cur_job_reg;
                                ht_next = cur_job_reg;
                                he_next = 1'b0;
                            end else begin
                                if (ln_we) begin
                                    // port busy with the boost link, hold it
                                    ln_pend_next      = 1'b1;
                                    ln_pend_addr_next = ht_next;
                                    ln_pend_data_next = cur_job_reg;
                                end else begin
                                    ln_we = 1'b1;
                                    ln_wa = ht_next;
                                    ln_wd = cur_job_reg;
                                end
                                ht_next = cur_job_reg;
                            end
                        end
                    end
                    jb_wd = rec_w;
                end else begin
                    tick_next = tick_reg + 32'd1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (ln_pend_reg) begin
                    ln_we = 1'b1;
                    ln_wa = ln_pend_addr_reg;
                    ln_wd = ln_pend_data_reg;
                    ln_pend_next = 1'b0;
                end
                if (m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            quantum_reg      <= 8'(QUANTUM_RESET);
            boost_period_reg <= 16'(BOOST_RESET);
            high_head_reg    <= '0;
            high_tail_reg    <= '0;
            low_head_reg     <= '0;
            low_tail_reg     <= '0;
            high_empty_reg   <= 1'b1;
            low_empty_reg    <= 1'b1;
            cur_valid_reg    <= 1'b0;
            cur_job_reg      <= '0;
            cur_level_reg    <= 1'b0;
            qleft_reg        <= '0;
            tick_reg         <= '0;
            bcount_reg       <= 16'(BOOST_RESET);
            active_reg       <= '0;
            started_reg      <= '0;
            picked_reg       <= 1'b0;
            pick_low_reg     <= 1'b0;
            rej_reg          <= 1'b0;
            ln_fwd_reg       <= 1'b0;
            jb_fwd_reg       <= 1'b0;
            ln_pend_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            high_head_reg  <= hh_next;
            high_tail_reg  <= ht_next;
            low_head_reg   <= lh_next;
            low_tail_reg   <= lt_next;
            high_empty_reg <= he_next;
            low_empty_reg  <= le_next;
            cur_valid_reg  <= cur_valid_next;
            cur_job_reg    <= cur_job_next;
            cur_level_reg  <= cur_level_next;
            qleft_reg      <= qleft_next;
            tick_reg       <= tick_next;
            bcount_reg     <= bcount_next;
            active_reg     <= active_next;
            started_reg    <= started_next;
            picked_reg     <= picked_next;
            pick_low_reg   <= pick_low_next;
            rej_reg        <= rej_next;
            ln_fwd_reg     <= ln_fwd_next;
            jb_fwd_reg     <= jb_fwd_next;
            ln_pend_reg    <= ln_pend_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_QUANTUM: quantum_reg      <= cfg_wr_data[7:0];
                    CFG_BOOST:   boost_period_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg          <= out_next;
        ln_fwd_data_reg  <= ln_fwd_data_next;
        jb_fwd_data_reg  <= jb_fwd_data_next;
        ln_pend_addr_reg <= ln_pend_addr_next;
        ln_pend_data_reg <= ln_pend_data_next;
        if (s_axis_tvalid && s_axis_tready) begin
            act_reg   <= in_action;
            slot_reg  <= in_slot;
            burst_reg <= in_burst;
            allot_reg <= in_allot;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> (state_reg == ST_OUT))
        else $error("exec not followed by result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid_reg && state_reg == ST_OUT) |-> active_reg[cur_job_reg])
        else $error("running job not active");

endmodule

// ===== test/tlfq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlfq_checker
// watches both streams of the scheduler, predicts each tick and compares
// ----------------------------------------------------------------------------
// A private copy of the scheduler state (queues, slot table, counters and the
// two registers) is stepped once per accepted request. The expected result is
// queued and checked field by field against each accepted result.
// ----------------------------------------------------------------------------
module tlfq_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [111:0] m_axis_tdata,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wr_data,
    output int           failures,
    output int           pending
);
    import tlfq_pkg::*;

    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] allotment;
        logic [15:0] burst_length;
        logic [3:0]  arriving_job;
        logic        action;
    } tick_req_t;

    typedef struct packed {
        logic [6:0]  pad;
        logic        boosted;
        logic        arrival_rejected;
        logic [31:0] response_time;
        logic [31:0] turnaround;
        logic [31:0] end_time;
        logic        finished;
        logic        running_level;
        logic [3:0]  running_job;
        logic        running_valid;
    } tick_res_t;

    logic [7:0]  quantum_reg;
    logic [15:0] boost_reg;

    logic [3:0]  link [16];
    logic [15:0] work [16];
    logic [15:0] allot_now [16];
    logic [15:0] allot_max [16];
    logic [31:0] arrive_tick [16];
    logic [31:0] start_tick [16];
    logic        started [16];
    logic        busy_slot [16];

    logic [3:0]  hi_head, hi_tail, lo_head, lo_tail;
    logic        hi_empty, lo_empty;
    logic        run_valid;
    logic [3:0]  run_job;
    logic        run_level;
    logic [7:0]  quantum_left;
    logic [31:0] now;
    logic [15:0] boost_count;

    tick_res_t expected_results [$];

    assign pending = expected_results.size();

    task automatic enqueue(input logic lvl, input logic [3:0] j);
        if (!lvl) begin
            if (hi_empty) begin
                hi_head = j;
                hi_empty = 1'b0;
            end else begin
                link[hi_tail] = j;
            end
            hi_tail = j;
        end else begin
            if (lo_empty) begin
                lo_head = j;
                lo_empty = 1'b0;
            end else begin
                link[lo_tail] = j;
            end
            lo_tail = j;
        end
    endtask

    task automatic dequeue(input logic lvl, output logic [3:0] j);
        if (!lvl) begin
            j = hi_head;
            if (hi_head == hi_tail) hi_empty = 1'b1;
            else hi_head = link[j];
        end else begin
            j = lo_head;
            if (lo_head == lo_tail) lo_empty = 1'b1;
            else lo_head = link[j];
        end
    endtask

    task automatic schedule_tick(input tick_req_t r, output tick_res_t o);
        logic [3:0]  j;
        logic [15:0] b;
        logic [15:0] a;
        o = '0;
        if (r.action) begin
            if (busy_slot[r.arriving_job]) begin
                o.arrival_rejected = 1'b1;
            end else begin
                j = r.arriving_job;
                b = r.burst_length == 16'd0 ? 16'd1 : r.burst_length;
                a = r.allotment == 16'd0 ? 16'd1 : r.allotment;
                work[j] = b;
                allot_max[j] = a;
                allot_now[j] = a;
                arrive_tick[j] = now;
                started[j] = 1'b0;
                busy_slot[j] = 1'b1;
                enqueue(1'b0, j);
            end
        end
        if (!run_valid) begin
            if (!hi_empty) begin
                dequeue(1'b0, run_job);
                run_level = 1'b0;
                run_valid = 1'b1;
            end else if (!lo_empty) begin
                dequeue(1'b1, run_job);
                run_level = 1'b1;
                run_valid = 1'b1;
            end
            if (run_valid) quantum_left = quantum_reg == 8'd0 ? 8'd1 : quantum_reg;
        end
        now = now + 32'd1;
        if (run_valid) begin
            j = run_job;
            o.running_valid = 1'b1;
            o.running_job = j;
            o.running_level = run_level;
            if (!started[j]) begin
                started[j] = 1'b1;
                start_tick[j] = now - 32'd1;
            end
            work[j] = work[j] - 16'd1;
            allot_now[j] = allot_now[j] - 16'd1;
            quantum_left = quantum_left - 8'd1;
            boost_count = boost_count - 16'd1;
            if (boost_count == 16'd0) begin
                if (!lo_empty) begin
                    if (hi_empty) begin
                        hi_head = lo_head;
                        hi_empty = 1'b0;
                    end else begin
                        link[hi_tail] = lo_head;
                    end
                    hi_tail = lo_tail;
                    lo_empty = 1'b1;
                    lo_head = '0;
                    lo_tail = '0;
                end
                run_level = 1'b0;
                boost_count = boost_reg;
                o.boosted = 1'b1;
            end
            if (work[j] == 16'd0) begin
                o.finished = 1'b1;
                o.end_time = now;
                o.turnaround = now - arrive_tick[j];
                o.response_time = start_tick[j] - arrive_tick[j];
                busy_slot[j] = 1'b0;
                run_valid = 1'b0;
            end else if (allot_now[j] == 16'd0) begin
                allot_now[j] = allot_max[j];
                enqueue(1'b1, j);
                run_valid = 1'b0;
            end else if (quantum_left == 8'd0) begin
                enqueue(run_level, j);
                run_valid = 1'b0;
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            failures++;
        end
    endtask

    initial failures = 0;

    always @(posedge aclk) begin
        tick_res_t want;
        tick_res_t got;
        if (!aresetn) begin
            quantum_reg = 8'(QUANTUM_RESET);
            boost_reg = 16'(BOOST_RESET);
            for (int i = 0; i < 16; i++) begin
                started[i] = 1'b0;
                busy_slot[i] = 1'b0;
            end
            hi_head = '0; hi_tail = '0; lo_head = '0; lo_tail = '0;
            hi_empty = 1'b1;
            lo_empty = 1'b1;
            run_valid = 1'b0;
            run_job = '0;
            run_level = 1'b0;
            quantum_left = '0;
            now = '0;
            boost_count = 16'(BOOST_RESET);
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_QUANTUM) quantum_reg = cfg_wr_data[7:0];
                else boost_reg = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                schedule_tick(tick_req_t'(s_axis_tdata), want);
                expected_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = tick_res_t'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    $display("mismatch at %0t: result with no request waiting", $realtime);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    report("running_valid", got.running_valid, want.running_valid);
                    report("running_job", got.running_job, want.running_job);
                    report("running_level", got.running_level, want.running_level);
                    report("finished", got.finished, want.finished);
                    report("end_time", got.end_time, want.end_time);
                    report("turnaround", got.turnaround, want.turnaround);
                    report("response_time", got.response_time, want.response_time);
                    report("arrival_rejected", got.arrival_rejected, want.arrival_rejected);
                    report("boosted", got.boosted, want.boosted);
                    report("padding", got.pad, want.pad);
                end
            end
        end
    end

endmodule

// ===== test/two_level_feedback_queue_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_feedback_queue_scheduler_test
// stimulus and verdict for the two-level feedback queue scheduler
// ----------------------------------------------------------------------------
// A directed burst of arrivals and ticks is followed by random requests in
// phases with different register settings and different idle and stall
// patterns on both streams, one phase with a long result hold-off.
// Checking is done by tlfq_checker.
// ----------------------------------------------------------------------------
module two_level_feedback_queue_scheduler_test;
    import tlfq_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = CFG_QUANTUM;
    logic [15:0]  cfg_wr_data = '0;

    int failures;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;

    two_level_feedback_queue_scheduler DUT (.*);

    tlfq_checker checker_i (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("two_level_feedback_queue_scheduler test failed");
        $finish;
    end

    // result side, with its own hold-off counter
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end else begin
                m_axis_tready <= $urandom_range(0, 99) >= stall_pct;
            end
        end
    end

    function automatic logic [39:0] pack_request(logic act, logic [3:0] job,
                                                 logic [15:0] burst, logic [15:0] allot);
        return {3'b000, allot, burst, job, act};
    endfunction

    function automatic logic [39:0] random_request();
        logic [15:0] burst;
        logic [15:0] allot;
        int pick;
        pick = $urandom_range(0, 99);
        burst = pick < 1 ? 16'($urandom) : pick < 4 ? 16'd0 : 16'($urandom_range(1, 40));
        pick = $urandom_range(0, 99);
        allot = pick < 6 ? 16'($urandom) : 16'($urandom_range(0, 30));
        return pack_request($urandom_range(0, 99) < 40, 4'($urandom), burst, allot);
    endfunction

    task automatic send_request(input logic [39:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    logic [7:0]  quanta [6] = '{8'd20, 8'd1, 8'd255, 8'd0, 8'd3, 8'd7};
    logic [15:0] boosts [6] = '{16'd100, 16'd1, 16'd65535, 16'd0, 16'd7, 16'd13};
    int          idles  [6] = '{0, 76, 0, 18, 0, 0};
    int          stalls [6] = '{0, 0, 76, 18, 0, 0};

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero burst and allotment, field extremes, rejection, demotion and rotation
        send_request(pack_request(1'b1, 4'd0, 16'd0, 16'd0));
        send_request(pack_request(1'b1, 4'd15, 16'd1, 16'hffff));
        send_request(pack_request(1'b1, 4'd1, 16'hffff, 16'd1));
        send_request(pack_request(1'b1, 4'd1, 16'd5, 16'd5));
        send_request(pack_request(1'b0, 4'd0, 16'd0, 16'd0));
        send_request(pack_request(1'b1, 4'd2, 16'd30, 16'd4));
        send_request(pack_request(1'b1, 4'd3, 16'd45, 16'd50));
        send_request(pack_request(1'b1, 4'd3, 16'd2, 16'd2));
        for (int i = 0; i < 12; i++)
            send_request(pack_request(1'b0, 4'hf, 16'hffff, 16'hffff));

        for (int p = 0; p < 6; p++) begin
            if (p != 0) begin
                drain();
                write_reg(CFG_QUANTUM, {8'd0, quanta[p]});
                write_reg(CFG_BOOST, boosts[p]);
            end
            send_idle_pct = idles[p];
            stall_pct = stalls[p];
            if (p == 4) hold_off = 400;
            for (int i = 0; i < 105; i++)
                send_request(random_request());
        end
        drain();
        if (failures == 0) begin
            $display("two_level_feedback_queue_scheduler test passed");
        end else begin
            $display("two_level_feedback_queue_scheduler test failed");
        end
        $finish;
    end

endmodule
